### sv/bfsp_pkg.sv
// shared types, constants and helpers for the shortest path block
package bfsp_pkg;

   // default tower size, vertex count is three to this power
   localparam int DISCS_DEFAULT = 4;

   // field widths and positions on the stream ports
   localparam int VTX_W       = 7;
   localparam int DIST_OUT_W  = 7;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 8;
   localparam int FROM_LSB    = 0;
   localparam int TO_LSB      = 7;
   localparam int PRESENT_BIT = 14;
   localparam int START_LSB   = 15;
   localparam int END_LSB     = 22;

   // largest reported hop count
   localparam logic [DIST_OUT_W-1:0] OUT_DIST_MAX = 7'd127;

   // item kinds carried on req_tuser
   typedef enum logic [0:0] {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } bfsp_op_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_INIT,
      ST_ROW,
      ST_ROW_WAIT,
      ST_SCAN,
      ST_DRAIN,
      ST_PASS_END,
      ST_FIN_RD,
      ST_FIN_WAIT
   } bfsp_state_type;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic capture;
      logic clear_step;
      logic load_wr;
      logic init_wr;
      logic pass_begin;
      logic row_rd;
      logic row_latch;
      logic row_next;
      logic scan;
      logic fin_rd;
      logic rsp_load;
   } bfsp_cmd_type;

   // status from the datapath to the sequencer
   typedef struct packed {
      logic clear_last;
      logic v_last;
      logic u_last;
      logic u_reached;
      logic changed;
      logic out_free;
   } bfsp_stat_type;

   // three to the power n, evaluated at elaboration
   function automatic int pow3(input int n);
      int acc;
      acc = 1;
      for (int k = 0; k < n; k++) begin
         acc = acc * 3;
      end
      return acc;
   endfunction

endpackage

### sv/bfsp_ctrl.sv
// sequencer for loads, memory clearing and relaxation passes
module bfsp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tuser,
   output logic                    req_tready,
   output bfsp_pkg::bfsp_cmd_type  cmd,
   input  bfsp_pkg::bfsp_stat_type stat
);

   bfsp_pkg::bfsp_state_type state_ff;
   bfsp_pkg::bfsp_state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfsp_pkg::ST_CLEAR: begin
            if (stat.clear_last) state_in = bfsp_pkg::ST_IDLE;
         end
         bfsp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (bfsp_pkg::bfsp_op_type'(req_tuser) == bfsp_pkg::OP_LOAD) begin
                  state_in = bfsp_pkg::ST_LOAD;
               end else begin
                  state_in = bfsp_pkg::ST_INIT;
               end
            end
         end
         bfsp_pkg::ST_LOAD: state_in = bfsp_pkg::ST_IDLE;
         bfsp_pkg::ST_INIT: begin
            if (stat.v_last) state_in = bfsp_pkg::ST_ROW;
         end
         bfsp_pkg::ST_ROW: state_in = bfsp_pkg::ST_ROW_WAIT;
         bfsp_pkg::ST_ROW_WAIT: begin
            if (stat.u_reached) begin
               state_in = bfsp_pkg::ST_SCAN;
            end else if (stat.u_last) begin
               state_in = bfsp_pkg::ST_PASS_END;
            end else begin
               state_in = bfsp_pkg::ST_ROW;
            end
         end
         bfsp_pkg::ST_SCAN: begin
            if (stat.v_last) state_in = bfsp_pkg::ST_DRAIN;
         end
         bfsp_pkg::ST_DRAIN: begin
            if (stat.u_last) begin
               state_in = bfsp_pkg::ST_PASS_END;
            end else begin
               state_in = bfsp_pkg::ST_ROW;
            end
         end
         bfsp_pkg::ST_PASS_END: begin
            if (stat.changed) begin
               state_in = bfsp_pkg::ST_ROW;
            end else begin
               state_in = bfsp_pkg::ST_FIN_RD;
            end
         end
         bfsp_pkg::ST_FIN_RD: state_in = bfsp_pkg::ST_FIN_WAIT;
         bfsp_pkg::ST_FIN_WAIT: begin
            if (stat.out_free) state_in = bfsp_pkg::ST_IDLE;
         end
         default: state_in = bfsp_pkg::ST_IDLE;
      endcase
   end

   // command decode
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         bfsp_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         bfsp_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         bfsp_pkg::ST_LOAD: cmd.load_wr = 1'b1;
         bfsp_pkg::ST_INIT: begin
            cmd.init_wr    = 1'b1;
            cmd.pass_begin = stat.v_last;
         end
         bfsp_pkg::ST_ROW: cmd.row_rd = 1'b1;
         bfsp_pkg::ST_ROW_WAIT: begin
            cmd.row_latch = stat.u_reached;
            cmd.row_next  = !stat.u_reached;
         end
         bfsp_pkg::ST_SCAN: cmd.scan = 1'b1;
         bfsp_pkg::ST_DRAIN: cmd.row_next = 1'b1;
         bfsp_pkg::ST_PASS_END: cmd.pass_begin = stat.changed;
         bfsp_pkg::ST_FIN_RD: cmd.fin_rd = 1'b1;
         bfsp_pkg::ST_FIN_WAIT: cmd.rsp_load = stat.out_free;
         default: cmd = '0;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfsp_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // a load write always follows an accepted item
   a_load_after_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == bfsp_pkg::ST_LOAD |-> $past(cmd.capture))
      else $error("load write without accepted item");

endmodule

### sv/bfsp_dpath.sv
// adjacency and distance memories, counters, relaxation and result register
module bfsp_dpath #(
   parameter int DISCS = bfsp_pkg::DISCS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bfsp_pkg::bfsp_cmd_type              cmd,
   output bfsp_pkg::bfsp_stat_type             stat,
   input  logic [bfsp_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [bfsp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser
);

   localparam int VERTICES = bfsp_pkg::pow3(DISCS);
   localparam int CELLS    = VERTICES * VERTICES;
   localparam int VW       = $clog2(VERTICES);
   localparam int AW       = $clog2(CELLS);
   localparam int DW       = $clog2(VERTICES);
   localparam int VTX_W    = bfsp_pkg::VTX_W;

   typedef struct packed {
      logic          reached;
      logic [DW-1:0] hops;
   } dist_entry_type;

   // memories
   logic           adj_mem  [CELLS];
   dist_entry_type dist_mem [VERTICES];

   // input fields
   logic [VTX_W-1:0] f_from, f_to, f_start, f_end;
   assign f_from  = req_tdata[bfsp_pkg::FROM_LSB +: VTX_W];
   assign f_to    = req_tdata[bfsp_pkg::TO_LSB +: VTX_W];
   assign f_start = req_tdata[bfsp_pkg::START_LSB +: VTX_W];
   assign f_end   = req_tdata[bfsp_pkg::END_LSB +: VTX_W];

   // registers
   logic [VW-1:0]  from_ff, from_in, to_ff, to_in, start_ff, start_in, end_ff, end_in;
   logic           present_ff, present_in, load_ok_ff, load_ok_in;
   logic           start_ok_ff, start_ok_in, end_ok_ff, end_ok_in;
   logic [AW-1:0]  addr_ff, addr_in, row_base_ff, row_base_in;
   logic [VW-1:0]  u_ff, u_in, v_ff, v_in, pend_v_ff, pend_v_in;
   logic [DW-1:0]  du_ff, du_in;
   logic           pend_ff, pend_in, changed_ff, changed_in;
   logic           adj_rd_ff;
   dist_entry_type dist_rd_ff;
   logic           rsp_valid_ff, rsp_valid_in, rsp_reach_ff, rsp_reach_in;
   logic [bfsp_pkg::DIST_OUT_W-1:0] rsp_dist_ff, rsp_dist_in;

   // relaxation of one edge, in the cycle after its reads
   logic [DW:0]    wb_d;
   logic           wb_upd;
   assign wb_d   = {1'b0, du_ff} + {{DW{1'b0}}, 1'b1};
   assign wb_upd = pend_ff && adj_rd_ff
                   && (!dist_rd_ff.reached || wb_d < {1'b0, dist_rd_ff.hops});

   // load address, row times vertex count plus column
   logic [AW-1:0]  load_addr;
   assign load_addr = AW'(from_ff) * AW'(VERTICES) + AW'(to_ff);

   // distance memory port selection
   logic           dist_we, dist_re;
   logic [VW-1:0]  dist_waddr, dist_raddr;
   dist_entry_type dist_wdata;

   always_comb begin
      dist_we    = cmd.init_wr || wb_upd;
      dist_waddr = cmd.init_wr ? v_ff : pend_v_ff;
      if (cmd.init_wr) begin
         dist_wdata.reached = start_ok_ff && (v_ff == start_ff);
         dist_wdata.hops    = '0;
      end else begin
         dist_wdata.reached = 1'b1;
         dist_wdata.hops    = DW'(wb_d);
      end
      dist_re = cmd.row_rd || cmd.scan || cmd.fin_rd;
      if (cmd.row_rd) begin
         dist_raddr = u_ff;
      end else if (cmd.fin_rd) begin
         dist_raddr = end_ff;
      end else begin
         dist_raddr = v_ff;
      end
   end

   // next values of counters and captured fields
   always_comb begin
      from_in     = from_ff;
      to_in       = to_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      present_in  = present_ff;
      load_ok_in  = load_ok_ff;
      start_ok_in = start_ok_ff;
      end_ok_in   = end_ok_ff;
      addr_in     = addr_ff;
      row_base_in = row_base_ff;
      u_in        = u_ff;
      v_in        = v_ff;
      pend_v_in   = pend_v_ff;
      du_in       = du_ff;
      pend_in     = 1'b0;
      changed_in  = changed_ff;

      if (cmd.capture) begin
         from_in     = VW'(f_from);
         to_in       = VW'(f_to);
         start_in    = VW'(f_start);
         end_in      = VW'(f_end);
         present_in  = req_tdata[bfsp_pkg::PRESENT_BIT];
         load_ok_in  = (32'(f_from) < 32'(VERTICES)) && (32'(f_to) < 32'(VERTICES));
         start_ok_in = 32'(f_start) < 32'(VERTICES);
         end_ok_in   = 32'(f_end) < 32'(VERTICES);
         v_in        = '0;
         changed_in  = 1'b0;
      end
      if (cmd.clear_step) begin
         addr_in = addr_ff + AW'(1);
      end
      if (cmd.init_wr) begin
         v_in = stat.v_last ? '0 : v_ff + VW'(1);
      end
      if (cmd.row_latch) begin
         du_in   = dist_rd_ff.hops;
         addr_in = row_base_ff;
         v_in    = '0;
      end
      if (cmd.scan) begin
         addr_in   = addr_ff + AW'(1);
         v_in      = stat.v_last ? '0 : v_ff + VW'(1);
         pend_in   = 1'b1;
         pend_v_in = v_ff;
      end
      if (wb_upd) begin
         changed_in = 1'b1;
      end
      if (cmd.row_next) begin
         u_in        = u_ff + VW'(1);
         row_base_in = row_base_ff + AW'(VERTICES);
      end
      if (cmd.pass_begin) begin
         u_in        = '0;
         row_base_in = '0;
         changed_in  = 1'b0;
      end
   end

   // result register, saturated hop count
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_reach_in = rsp_reach_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_reach_in = end_ok_ff && dist_rd_ff.reached;
         if (!(end_ok_ff && dist_rd_ff.reached)) begin
            rsp_dist_in = '0;
         end else if (32'(dist_rd_ff.hops) > 32'(bfsp_pkg::OUT_DIST_MAX)) begin
            rsp_dist_in = bfsp_pkg::OUT_DIST_MAX;
         end else begin
            rsp_dist_in = bfsp_pkg::DIST_OUT_W'(dist_rd_ff.hops);
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      from_ff      <= from_in;
      to_ff        <= to_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      present_ff   <= present_in;
      load_ok_ff   <= load_ok_in;
      start_ok_ff  <= start_ok_in;
      end_ok_ff    <= end_ok_in;
      row_base_ff  <= row_base_in;
      u_ff         <= u_in;
      v_ff         <= v_in;
      pend_v_ff    <= pend_v_in;
      du_ff        <= du_in;
      changed_ff   <= changed_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_reach_ff <= rsp_reach_in;
   end

   // adjacency memory, clear sweep or single bit load, registered read
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         adj_mem[addr_ff] <= 1'b0;
      end else if (cmd.load_wr && load_ok_ff) begin
         adj_mem[load_addr] <= present_ff;
      end
      if (cmd.scan) begin
         adj_rd_ff <= adj_mem[addr_ff];
      end
   end

   // distance memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_waddr] <= dist_wdata;
      end
      if (dist_re) begin
         dist_rd_ff <= dist_mem[dist_raddr];
      end
   end

   // status
   assign stat.clear_last = addr_ff == AW'(CELLS - 1);
   assign stat.v_last     = v_ff == VW'(VERTICES - 1);
   assign stat.u_last     = u_ff == VW'(VERTICES - 1);
   assign stat.u_reached  = dist_rd_ff.reached;
   assign stat.changed    = changed_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;

   // result port, hop count padded to a byte
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = bfsp_pkg::RSP_DATA_W'(rsp_dist_ff);
   assign rsp_tuser  = rsp_reach_ff;

   // no row or final read while a distance write is still pending
   a_no_read_over_wb: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !cmd.row_rd && !cmd.fin_rd)
      else $error("distance read issued over pending write");

   // running scan address tracks row base plus column
   a_scan_addr: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> addr_ff == row_base_ff + AW'(v_ff))
      else $error("scan address out of step");

   // a result is never loaded over one not yet taken
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !rsp_valid_ff || rsp_tready)
      else $error("result overwritten");

endmodule

### sv/bellman_ford_shortest_path.sv
// top level of the hop count shortest path engine over a stored bit matrix
//
// channel | direction | tdata (low bit up)                         | tuser
// req_    | in        | edge_from, edge_to, edge_present,          | operation
//         |           | start_vertex, end_vertex, zero pad to 32   |
// rsp_    | out       | distance, zero pad to 8                    | reachable
//
// after reset the adjacency memory is cleared one bit a cycle, all VERTICES^2
// bits (6561 at four discs), with req_tready low throughout.
// a load item is captured, then written, and gives no result.
// a query first resets the distance memory; each pass then reads every row
// distance, scans each reached row one edge a cycle through the single
// adjacency read port, skips each other row and closes the pass; passes
// run until one changes nothing, at most VERTICES of them, then the end
// vertex distance is read and loaded into the result register.
// the result register lets the next item in while a result waits; a finished
// query waits only while the previous result has not been taken.
module bellman_ford_shortest_path #(
   parameter int DISCS = bfsp_pkg::DISCS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // edge_from[6:0], edge_to[13:7], edge_present[14], start_vertex[21:15],
   // end_vertex[28:22], zero[31:29]
   input  logic [bfsp_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation[0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // distance[6:0], zero[7]
   output logic [bfsp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // reachable[0]
   output logic                            rsp_tuser
);

   bfsp_pkg::bfsp_cmd_type  cmd;
   bfsp_pkg::bfsp_stat_type stat;

   // sequencer
   bfsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // memories and relaxation datapath
   bfsp_dpath #(
      .DISCS (DISCS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
